// ===== hdl/ata_pio_command_sequencer_defines.svh =====
// Assertion macros for the ATA PIO command sequencer.
// No dependencies; taken in by files that carry concurrent checks.
`ifndef ATA_PIO_COMMAND_SEQUENCER_DEFINES_SVH
`define ATA_PIO_COMMAND_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset
`define APCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("apcs check failed");
// Next-cycle implication, disabled while in reset
`define APCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("apcs check failed");
`else
`define APCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define APCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/apcs_pkg.sv =====
// Shared types, codes and constants of the ATA PIO command sequencer.
// No dependencies; imported by every module of the block.
package apcs_pkg;

  // Sizes
  localparam int WORDS_PER_SECTOR = 256;
  localparam int SETTLE_READS     = 4;
  localparam int WORD_W           = $clog2(WORDS_PER_SECTOR + 1);
  localparam int RES_MAX          = 6;
  localparam int CNT_W            = $clog2(RES_MAX + 1);

  // Task-file register offsets
  localparam logic [2:0] PORT_DATA  = 3'd0;
  localparam logic [2:0] PORT_COUNT = 3'd2;
  localparam logic [2:0] PORT_LBA0  = 3'd3;
  localparam logic [2:0] PORT_LBA1  = 3'd4;
  localparam logic [2:0] PORT_LBA2  = 3'd5;
  localparam logic [2:0] PORT_DRIVE = 3'd6;
  localparam logic [2:0] PORT_CMD   = 3'd7;

  // Drive select and command bytes
  localparam logic [7:0] DRV_MASTER = 8'hE0;
  localparam logic [7:0] DRV_SLAVE  = 8'hF0;
  localparam logic [7:0] FL_MASTER  = 8'hA0;
  localparam logic [7:0] FL_SLAVE   = 8'hB0;
  localparam logic [7:0] CMD_READ   = 8'h20;
  localparam logic [7:0] CMD_WRITE  = 8'h30;
  localparam logic [7:0] CMD_FLUSH  = 8'hE7;

  // Status bits
  localparam int ST_BSY_BIT = 7;
  localparam int ST_ERR_BIT = 0;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_HOST   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_HOST  = 2'd2,
    ACT_DONE  = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SELECT = 4'd1,
    PH_CMD    = 4'd2,
    PH_RDATA  = 4'd3,
    PH_WDATA  = 4'd4,
    PH_SECTOR = 4'd5,
    PH_FLUSH  = 4'd6
  } phase_t;

  // What one input item does to the sequencer
  typedef enum logic [3:0] {
    EV_NONE,
    EV_BAD_OP,
    EV_FLUSH,
    EV_SELECT,
    EV_ISSUE,
    EV_POLL,
    EV_FLUSH_OK,
    EV_FAIL,
    EV_SEL_OK,
    EV_DONE,
    EV_SECTOR,
    EV_RD_WORD,
    EV_WR_WORD
  } event_t;

  typedef struct packed {
    kind_t        kind;
    op_t          op;
    logic         drv;
    logic [23:0]  addr;
    logic [7:0]   count;
    logic [15:0]  resp;
    logic [15:0]  host;
  } item_t;

  typedef struct packed {
    phase_t              phase;
    logic [7:0]          last_sel;
    op_t                 cur_op;
    logic                cur_drv;
    logic [23:0]         addr;
    logic [7:0]          sectors;
    logic [WORD_W-1:0]   words;
    logic [2:0]          ign;
  } state_t;

  typedef struct packed {
    act_t         action;
    logic [2:0]   port;
    logic [15:0]  value;
    logic         failed;
  } res_t;

  function automatic res_t mk_res(act_t a, logic [2:0] p, logic [15:0] v, logic f);
    res_t r;
    r.action = a;
    r.port   = p;
    r.value  = v;
    r.failed = f;
    return r;
  endfunction

endpackage

// ===== hdl/apcs_step.sv =====
// Single-pass decode, next-state and result list for one input item.
// Depends on apcs_pkg.
module apcs_step
  import apcs_pkg::*;
(
  input  state_t                  st_i,
  input  item_t                   item_i,
  output state_t                  st_o,
  output res_t [RES_MAX-1:0]      list_o,
  output logic [CNT_W-1:0]        n_o
);

  event_t            ev;
  logic [7:0]        st_byte;
  logic              bsy;
  logic              err;
  logic [7:0]        start_code;
  logic [7:0]        kept_code;
  logic [7:0]        sect_dec;
  logic [WORD_W-1:0] word_dec;
  logic              word_end;

  assign st_byte    = item_i.resp[7:0];
  assign bsy        = st_byte[ST_BSY_BIT];
  assign err        = st_byte[ST_ERR_BIT];
  assign start_code = item_i.drv ? DRV_SLAVE : DRV_MASTER;
  assign kept_code  = st_i.cur_drv ? DRV_SLAVE : DRV_MASTER;
  assign sect_dec   = (st_i.sectors != 8'd0) ? st_i.sectors - 8'd1 : st_i.sectors;
  assign word_dec   = (st_i.words != '0) ? st_i.words - WORD_W'(1) : st_i.words;
  assign word_end   = (word_dec == '0);

  // Event decode
  always_comb begin
    ev = EV_NONE;
    unique case (item_i.kind)
      KIND_START: begin
        if (st_i.phase == PH_IDLE) begin
          priority if (item_i.op == OP_BAD) ev = EV_BAD_OP;
          else if (item_i.op == OP_FLUSH)   ev = EV_FLUSH;
          else if (start_code != st_i.last_sel) ev = EV_SELECT;
          else ev = EV_ISSUE;
        end
      end
      KIND_STATUS: begin
        if (st_i.phase == PH_SELECT || st_i.phase == PH_CMD ||
            st_i.phase == PH_SECTOR || st_i.phase == PH_FLUSH) begin
          priority if (st_i.ign != 3'd0 || bsy) ev = EV_POLL;
          else if (st_i.phase == PH_FLUSH) ev = EV_FLUSH_OK;
          else if (err) ev = EV_FAIL;
          else if (st_i.phase == PH_SELECT) ev = EV_SEL_OK;
          else if (st_i.phase == PH_CMD) ev = (st_i.sectors == 8'd0) ? EV_DONE : EV_SECTOR;
          else ev = (sect_dec == 8'd0) ? EV_DONE : EV_SECTOR;
        end
      end
      KIND_DATA: begin
        if (st_i.phase == PH_RDATA) ev = EV_RD_WORD;
      end
      KIND_HOST: begin
        if (st_i.phase == PH_WDATA) ev = EV_WR_WORD;
      end
      default: ev = EV_NONE;
    endcase
  end

  // Next state
  always_comb begin
    st_o = st_i;
    unique case (ev)
      EV_BAD_OP, EV_FLUSH_OK, EV_FAIL: st_o.phase = PH_IDLE;
      EV_FLUSH: begin
        st_o.cur_op  = item_i.op;
        st_o.cur_drv = item_i.drv;
        st_o.phase   = PH_FLUSH;
        st_o.ign     = 3'd0;
      end
      EV_SELECT, EV_ISSUE: begin
        st_o.cur_op  = item_i.op;
        st_o.cur_drv = item_i.drv;
        st_o.addr    = item_i.addr;
        st_o.sectors = item_i.count;
        st_o.words   = '0;
        st_o.phase   = (ev == EV_SELECT) ? PH_SELECT : PH_CMD;
        st_o.ign     = (ev == EV_SELECT) ? 3'(SETTLE_READS) : 3'd0;
      end
      EV_POLL: begin
        if (st_i.ign != 3'd0) st_o.ign = st_i.ign - 3'd1;
      end
      EV_SEL_OK: begin
        st_o.last_sel = kept_code;
        st_o.phase    = PH_CMD;
        st_o.ign      = 3'd0;
      end
      EV_DONE: begin
        if (st_i.phase == PH_SECTOR) st_o.sectors = sect_dec;
        st_o.phase = PH_IDLE;
      end
      EV_SECTOR: begin
        if (st_i.phase == PH_SECTOR) st_o.sectors = sect_dec;
        st_o.words = WORD_W'(WORDS_PER_SECTOR);
        st_o.phase = (st_i.cur_op == OP_WRITE) ? PH_WDATA : PH_RDATA;
      end
      EV_RD_WORD, EV_WR_WORD: begin
        st_o.words = word_dec;
        if (word_end) begin
          st_o.phase = PH_SECTOR;
          st_o.ign   = 3'(SETTLE_READS);
        end
      end
      default: st_o = st_i;
    endcase
  end

  // Result list
  always_comb begin
    list_o = '0;
    n_o    = '0;
    unique case (ev)
      EV_BAD_OP, EV_FAIL: begin
        list_o[0] = mk_res(ACT_DONE, 3'd0, 16'd0, 1'b1);
        n_o       = CNT_W'(1);
      end
      EV_FLUSH_OK, EV_DONE: begin
        list_o[0] = mk_res(ACT_DONE, 3'd0, 16'd0, 1'b0);
        n_o       = CNT_W'(1);
      end
      EV_FLUSH: begin
        list_o[0] = mk_res(ACT_WRITE, PORT_DRIVE,
                           {8'd0, (item_i.drv ? FL_SLAVE : FL_MASTER)}, 1'b0);
        list_o[1] = mk_res(ACT_WRITE, PORT_CMD, {8'd0, CMD_FLUSH}, 1'b0);
        list_o[2] = mk_res(ACT_READ, PORT_CMD, 16'd0, 1'b0);
        n_o       = CNT_W'(3);
      end
      EV_SELECT: begin
        list_o[0] = mk_res(ACT_WRITE, PORT_DRIVE, {8'd0, start_code}, 1'b0);
        list_o[1] = mk_res(ACT_READ, PORT_CMD, 16'd0, 1'b0);
        n_o       = CNT_W'(2);
      end
      EV_ISSUE, EV_SEL_OK: begin
        // programmed values come from the updated state in both cases
        list_o[0] = mk_res(ACT_WRITE, PORT_COUNT, {8'd0, st_o.sectors}, 1'b0);
        list_o[1] = mk_res(ACT_WRITE, PORT_LBA0, {8'd0, st_o.addr[7:0]}, 1'b0);
        list_o[2] = mk_res(ACT_WRITE, PORT_LBA1, {8'd0, st_o.addr[15:8]}, 1'b0);
        list_o[3] = mk_res(ACT_WRITE, PORT_LBA2, {8'd0, st_o.addr[23:16]}, 1'b0);
        list_o[4] = mk_res(ACT_WRITE, PORT_CMD,
                           {8'd0, (st_o.cur_op == OP_WRITE) ? CMD_WRITE : CMD_READ},
                           1'b0);
        list_o[5] = mk_res(ACT_READ, PORT_CMD, 16'd0, 1'b0);
        n_o       = CNT_W'(6);
      end
      EV_POLL: begin
        list_o[0] = mk_res(ACT_READ, PORT_CMD, 16'd0, 1'b0);
        n_o       = CNT_W'(1);
      end
      EV_SECTOR: begin
        // writes wait for host words; reads ask for the first data word
        if (st_i.cur_op != OP_WRITE) begin
          list_o[0] = mk_res(ACT_READ, PORT_DATA, 16'd0, 1'b0);
          n_o       = CNT_W'(1);
        end
      end
      EV_RD_WORD: begin
        list_o[0] = mk_res(ACT_HOST, 3'd0, item_i.resp, 1'b0);
        list_o[1] = mk_res(ACT_READ, word_end ? PORT_CMD : PORT_DATA, 16'd0, 1'b0);
        n_o       = CNT_W'(2);
      end
      EV_WR_WORD: begin
        list_o[0] = mk_res(ACT_WRITE, PORT_DATA, item_i.host, 1'b0);
        if (word_end) begin
          list_o[1] = mk_res(ACT_READ, PORT_CMD, 16'd0, 1'b0);
          n_o       = CNT_W'(2);
        end else begin
          n_o       = CNT_W'(1);
        end
      end
      default: n_o = '0;
    endcase
  end

endmodule

// ===== hdl/apcs_obuf.sv =====
// Result buffer: loads a whole result list, shifts it out one per transaction.
// Depends on apcs_pkg.
module apcs_obuf
  import apcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  res_t [RES_MAX-1:0]  list_i,
  input  logic [CNT_W-1:0]    n_i,
  output logic                empty_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,   // port_offset[2:0], value[18:3], failed[19]
  output logic [1:0]          out_tuser,   // action
  output logic                out_tlast
);

  typedef struct packed {
    res_t res;
    logic last;
  } ent_t;

  ent_t             ent_r   [RES_MAX];
  ent_t             ent_nxt [RES_MAX];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pop;

  assign pop     = out_tvalid && out_tready;
  assign empty_o = (cnt_r == '0);

  // Load (only when empty) or shift down on a transaction
  always_comb begin
    cnt_nxt = cnt_r;
    ent_nxt = ent_r;
    if (load_i) begin
      for (int i = 0; i < RES_MAX; i++) begin
        ent_nxt[i].res  = list_i[i];
        ent_nxt[i].last = (CNT_W'(i) == n_i - CNT_W'(1));
      end
      cnt_nxt = n_i;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // Head entry drives the port
  assign out_tvalid = !empty_o;
  assign out_tuser  = ent_r[0].res.action;
  assign out_tdata  = {4'd0, ent_r[0].res.failed, ent_r[0].res.value, ent_r[0].res.port};
  assign out_tlast  = ent_r[0].last;

endmodule

// ===== hdl/ata_pio_command_sequencer.sv =====
// An accepted item is held in an input register and processed in the next cycle that
// finds the result buffer empty; its first result shows in the cycle after.
// An item's results drain through the result buffer before the next item is processed;
// the input register takes a new item while the buffer drains only if it is empty.
// Reset (synchronous, rst_n low): phase idle, kept drive code and counters zero,
// input register and result buffer empty.
`include "ata_pio_command_sequencer_defines.svh"
module ata_pio_command_sequencer
  import apcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // operation[1:0], drive_number[2], sector_address[26:3],
                                   // sector_count[34:27], response_value[50:35],
                                   // host_word[66:51]
  input  logic [1:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // port_offset[2:0], value[18:3], failed[19]
  output logic [1:0]   out_tuser,  // action
  output logic         out_tlast
);

  item_t              item_r;
  logic               in_valid_r;
  logic               in_valid_nxt;
  state_t             st_r;
  state_t             st_nxt;
  res_t [RES_MAX-1:0] list;
  logic [CNT_W-1:0]   n_res;
  logic               obuf_empty;
  logic               proc;
  logic               accept;

  // Input register handshake
  assign proc      = in_valid_r && obuf_empty;
  assign in_tready = !in_valid_r || obuf_empty;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) in_valid_nxt = 1'b1;
    else if (proc) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= '{phase: PH_IDLE, cur_op: OP_READ, default: '0};
    end else begin
      in_valid_r <= in_valid_nxt;
      if (proc) st_r <= st_nxt;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind  <= kind_t'(in_tuser);
      item_r.op    <= op_t'(in_tdata[1:0]);
      item_r.drv   <= in_tdata[2];
      item_r.addr  <= in_tdata[26:3];
      item_r.count <= in_tdata[34:27];
      item_r.resp  <= in_tdata[50:35];
      item_r.host  <= in_tdata[66:51];
    end
  end

  apcs_step u_step (
    .st_i   (st_r),
    .item_i (item_r),
    .st_o   (st_nxt),
    .list_o (list),
    .n_o    (n_res)
  );

  apcs_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (proc && (n_res != '0)),
    .list_i     (list),
    .n_i        (n_res),
    .empty_o    (obuf_empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Checks
  `APCS_ASSERT_NXT(a_last_empties, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid)
  `APCS_ASSERT_NXT(a_run_continues, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid)
  `APCS_ASSERT_IMP(a_idle_no_settle, clk, rst_n, st_r.phase == PH_IDLE, st_r.ign == 3'd0)
  `APCS_ASSERT_IMP(a_data_words_left, clk, rst_n,
                   st_r.phase == PH_RDATA || st_r.phase == PH_WDATA, st_r.words != '0)

endmodule

// ===== tb/ata_pio_command_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the ATA PIO command sequencer: directed task-file sequences, then random
// command traffic answered by a behavioural device, each result checked against a predictor.
// Depends on apcs_pkg and the ata_pio_command_sequencer RTL only.
module ata_pio_command_sequencer_tb;
  import apcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam logic [2:0] NO_PORT = 3'd0;

  // One expected task-file access or host-side result
  typedef struct {
    act_t        action;
    logic [2:0]  port;
    logic [15:0] value;
    logic        failed;
    logic        last;
  } bus_access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // operation[1:0], drive_number[2], sector_address[26:3],
                                // sector_count[34:27], response_value[50:35],
                                // host_word[66:51]
  logic [1:0]  in_tuser = '0;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // port_offset[2:0], value[18:3], failed[19]
  logic [1:0]  out_tuser;       // action
  logic        out_tlast;

  ata_pio_command_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Predictor copy of the sequencer state
  phase_t            seq_phase        = PH_IDLE;
  logic [7:0]        kept_sel         = 8'h00;
  op_t               cmd_op           = OP_READ;
  logic              cmd_drive        = 1'b0;
  logic [23:0]       cmd_lba          = '0;
  logic [7:0]        sect_remaining   = '0;
  logic [WORD_W-1:0] word_remaining   = '0;
  logic [2:0]        settle_remaining = '0;

  bus_access_t step_accesses[$];
  bus_access_t expected_accesses[$];

  int items_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int commands_seen   = 0;
  int sectors_moved   = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int quiet_cycles    = 0;

  function automatic void queue_access(act_t a, logic [2:0] p, logic [15:0] v, logic f);
    bus_access_t acc;
    acc.action = a;
    acc.port   = p;
    acc.value  = v;
    acc.failed = f;
    acc.last   = 1'b0;
    step_accesses.push_back(acc);
  endfunction

  function automatic void end_command(logic fail);
    queue_access(ACT_DONE, NO_PORT, 16'h0000, fail);
    seq_phase = PH_IDLE;
    commands_seen++;
  endfunction

  // Status poll, optionally preceded by the discarded settle reads
  function automatic void start_status_wait(phase_t next, logic settle);
    seq_phase = next;
    settle_remaining = settle ? 3'(SETTLE_READS) : 3'd0;
    queue_access(ACT_READ, PORT_CMD, 16'h0000, 1'b0);
  endfunction

  function automatic void program_taskfile();
    queue_access(ACT_WRITE, PORT_COUNT, {8'h00, sect_remaining}, 1'b0);
    queue_access(ACT_WRITE, PORT_LBA0, {8'h00, cmd_lba[7:0]}, 1'b0);
    queue_access(ACT_WRITE, PORT_LBA1, {8'h00, cmd_lba[15:8]}, 1'b0);
    queue_access(ACT_WRITE, PORT_LBA2, {8'h00, cmd_lba[23:16]}, 1'b0);
    queue_access(ACT_WRITE, PORT_CMD,
                 {8'h00, (cmd_op == OP_WRITE) ? CMD_WRITE : CMD_READ}, 1'b0);
    start_status_wait(PH_CMD, 1'b0);
  endfunction

  function automatic void open_sector();
    word_remaining = WORD_W'(WORDS_PER_SECTOR);
    if (cmd_op == OP_WRITE) begin
      seq_phase = PH_WDATA;
    end else begin
      seq_phase = PH_RDATA;
      queue_access(ACT_READ, PORT_DATA, 16'h0000, 1'b0);
    end
  endfunction

  function automatic void count_word();
    if (word_remaining != 0) word_remaining--;
    if (word_remaining == 0) begin
      sectors_moved++;
      start_status_wait(PH_SECTOR, 1'b1);
    end else if (cmd_op != OP_WRITE) begin
      queue_access(ACT_READ, PORT_DATA, 16'h0000, 1'b0);
    end
  endfunction

  // Works out the results of one accepted transaction and queues them
  function automatic void predict_item(item_t it);
    logic [7:0] st;
    logic [7:0] code;
    st = it.resp[7:0];
    step_accesses.delete();
    case (it.kind)
      KIND_START: begin
        if (seq_phase == PH_IDLE) begin
          if (it.op == OP_BAD) begin
            end_command(1'b1);
          end else begin
            cmd_op = it.op;
            cmd_drive = it.drv;
            if (it.op == OP_FLUSH) begin
              // flush never touches the kept select code
              queue_access(ACT_WRITE, PORT_DRIVE,
                           {8'h00, it.drv ? FL_SLAVE : FL_MASTER}, 1'b0);
              queue_access(ACT_WRITE, PORT_CMD, {8'h00, CMD_FLUSH}, 1'b0);
              start_status_wait(PH_FLUSH, 1'b0);
            end else begin
              cmd_lba = it.addr;
              sect_remaining = it.count;
              word_remaining = '0;
              code = it.drv ? DRV_SLAVE : DRV_MASTER;
              if (code != kept_sel) begin
                queue_access(ACT_WRITE, PORT_DRIVE, {8'h00, code}, 1'b0);
                start_status_wait(PH_SELECT, 1'b1);
              end else begin
                program_taskfile();
              end
            end
          end
        end
      end
      KIND_STATUS: begin
        if (seq_phase inside {PH_SELECT, PH_CMD, PH_SECTOR, PH_FLUSH}) begin
          if (settle_remaining != 0) begin
            settle_remaining--;
            queue_access(ACT_READ, PORT_CMD, 16'h0000, 1'b0);
          end else if (st[ST_BSY_BIT]) begin
            queue_access(ACT_READ, PORT_CMD, 16'h0000, 1'b0);
          end else begin
            case (seq_phase)
              PH_FLUSH: end_command(1'b0);
              PH_SELECT: begin
                if (st[ST_ERR_BIT]) begin
                  end_command(1'b1);
                end else begin
                  kept_sel = cmd_drive ? DRV_SLAVE : DRV_MASTER;
                  program_taskfile();
                end
              end
              PH_CMD: begin
                if (st[ST_ERR_BIT]) end_command(1'b1);
                else if (sect_remaining == 0) end_command(1'b0);
                else open_sector();
              end
              PH_SECTOR: begin
                if (st[ST_ERR_BIT]) begin
                  end_command(1'b1);
                end else begin
                  if (sect_remaining != 0) sect_remaining--;
                  if (sect_remaining == 0) end_command(1'b0);
                  else open_sector();
                end
              end
              default: ;
            endcase
          end
        end
      end
      KIND_DATA: begin
        if (seq_phase == PH_RDATA) begin
          queue_access(ACT_HOST, NO_PORT, it.resp, 1'b0);
          count_word();
        end
      end
      KIND_HOST: begin
        if (seq_phase == PH_WDATA) begin
          queue_access(ACT_WRITE, PORT_DATA, it.host, 1'b0);
          count_word();
        end
      end
      default: ;
    endcase
    if (step_accesses.size() != 0) step_accesses[$].last = 1'b1;
    foreach (step_accesses[i]) expected_accesses.push_back(step_accesses[i]);
  endfunction

  function automatic item_t make_item(kind_t k, op_t o, logic d, logic [23:0] a,
                                      logic [7:0] c, logic [15:0] r, logic [15:0] h);
    item_t it;
    it.kind  = k;
    it.op    = o;
    it.drv   = d;
    it.addr  = a;
    it.count = c;
    it.resp  = r;
    it.host  = h;
    return it;
  endfunction

  // Behavioural device and host: mostly well-formed replies, some noise
  function automatic item_t next_traffic_item();
    item_t it;
    logic  err;
    int    pick;
    it.kind  = kind_t'($urandom_range(3));
    it.op    = op_t'($urandom_range(3));
    it.drv   = 1'($urandom_range(1));
    it.addr  = 24'($urandom);
    it.count = 8'($urandom);
    it.resp  = 16'($urandom);
    it.host  = 16'($urandom);
    if ($urandom_range(99) >= 8) begin
      case (seq_phase)
        PH_IDLE: begin
          it.kind = KIND_START;
          pick = $urandom_range(99);
          if (pick < 40) it.op = OP_READ;
          else if (pick < 80) it.op = OP_WRITE;
          else if (pick < 95) it.op = OP_FLUSH;
          else it.op = OP_BAD;
          if ($urandom_range(99) < 60) it.count = 8'($urandom_range(2));
        end
        PH_RDATA: it.kind = KIND_DATA;
        PH_WDATA: it.kind = KIND_HOST;
        default: begin
          it.kind = KIND_STATUS;
          if (settle_remaining == 0) begin
            it.resp[ST_BSY_BIT] = ($urandom_range(99) < 25);
            case (seq_phase)
              PH_SELECT: err = ($urandom_range(99) < 8);
              PH_CMD:    err = ($urandom_range(99) < 6);
              PH_SECTOR: err = ($urandom_range(99) < 5);
              default:   err = 1'($urandom_range(1));
            endcase
            it.resp[ST_ERR_BIT] = err;
          end
        end
      endcase
    end
    // transfers with data are cut short by the device at the command wait;
    // the sector data phase has a directed test of its own
    if (it.kind == KIND_STATUS && seq_phase == PH_CMD && sect_remaining != 0)
      it.resp[ST_ERR_BIT] = 1'b1;
    return it;
  endfunction

  // Offers one transaction, waits for the handshake, then predicts its results
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {5'b0, it.host, it.resp, it.count, it.addr, it.drv, it.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  task automatic test_ignored_and_bad_op();
    send_item(make_item(KIND_START, OP_BAD, 1'b1, 24'hFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0000, 16'h0));
    send_item(make_item(KIND_DATA, OP_READ, 1'b0, 24'h0, 8'h0, 16'hFFFF, 16'h0));
    send_item(make_item(KIND_HOST, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0, 16'hFFFF));
  endtask

  // Select with settle reads carrying BSY and ERR, a start while busy and a zero count
  task automatic test_select_and_settle();
    send_item(make_item(KIND_START, OP_READ, 1'b0, 24'h000000, 8'h00, 16'h0, 16'h0));
    send_item(make_item(KIND_START, OP_WRITE, 1'b1, 24'hABCDEF, 8'h05, 16'h0, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0081, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h00FF, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'hFF80, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0001, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0080, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'hFF00, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0100, 16'h0));
  endtask

  // Flush with ERR, command error, and a select error that keeps the old code
  task automatic test_flush_and_errors();
    send_item(make_item(KIND_START, OP_FLUSH, 1'b1, 24'h0, 8'h0, 16'h0, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0001, 16'h0));
    send_item(make_item(KIND_START, OP_WRITE, 1'b0, 24'h123456, 8'h01, 16'h0, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0041, 16'h0));
    send_item(make_item(KIND_START, OP_READ, 1'b1, 24'hFFFFFF, 8'hFF, 16'h0, 16'h0));
    repeat (SETTLE_READS)
      send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0000, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0001, 16'h0));
  endtask

  // One full sector read: data words to the host, then the settled sector wait
  task automatic test_one_sector_read();
    logic [15:0] data_word;
    data_word = 16'h1357;
    send_item(make_item(KIND_START, OP_READ, 1'b0, 24'h00FEDC, 8'h01, 16'h0, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0000, 16'h0));
    repeat (WORDS_PER_SECTOR) begin
      send_item(make_item(KIND_DATA, OP_READ, 1'b0, 24'h0, 8'h0, data_word, 16'h0));
      data_word = data_word + 16'h9E37;
    end
    repeat (SETTLE_READS)
      send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0081, 16'h0));
    send_item(make_item(KIND_STATUS, OP_READ, 1'b0, 24'h0, 8'h0, 16'h0000, 16'h0));
  endtask

  // Random traffic under one idling profile; always ends with the block idle
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    int first;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < n || seq_phase != PH_IDLE) send_item(next_traffic_item());
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    bus_access_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_accesses.size() == 0) begin
        $error("unexpected result: action %0d, data 0x%0h, last %0b",
               out_tuser, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = expected_accesses.pop_front();
        results_checked++;
        check_field("action", 16'(want.action), 16'(out_tuser));
        check_field("port_offset", 16'(want.port), 16'(out_tdata[2:0]));
        check_field("value", want.value, out_tdata[18:3]);
        check_field("failed", 16'(want.failed), 16'(out_tdata[19]));
        check_field("last", 16'(want.last), 16'(out_tlast));
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ata_pio_command_sequencer verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 13;
    recv_stall_pct = 13;
    test_ignored_and_bad_op();
    test_select_and_settle();
    test_flush_and_errors();
    test_one_sector_read();

    test_random_traffic(0, 0, 6);
    test_random_traffic(53, 0, 6);
    test_random_traffic(0, 53, 6);
    test_random_traffic(13, 13, 6);
    in_tvalid <= 1'b0;

    while (expected_accesses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d input transactions, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("Covered %0d finished commands and %0d full sectors over four idling profiles",
             commands_seen, sectors_moved);
    if (mismatches == 0) begin
      $display("ata_pio_command_sequencer verification clean");
    end else begin
      $display("ata_pio_command_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== ata_pio_command_sequencer.f =====
+incdir+hdl
hdl/apcs_pkg.sv
hdl/apcs_step.sv
hdl/apcs_obuf.sv
hdl/ata_pio_command_sequencer.sv
tb/ata_pio_command_sequencer_tb.sv
